/* src/ptagl_pkg.sv */
package ptagl_pkg;

   localparam int MAX_STEPS = 256;
   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam int CORNER_W = 64;
   localparam int NUM_CORNERS = 4;
   localparam int IDX_W = 2;

   localparam logic [IDX_W-1:0] REG_BL = 2'd0;
   localparam logic [IDX_W-1:0] REG_BR = 2'd1;
   localparam logic [IDX_W-1:0] REG_TL = 2'd2;
   localparam logic [IDX_W-1:0] REG_TR = 2'd3;

   localparam logic [1:0] ST_FOUND    = 2'd0;
   localparam logic [1:0] ST_ROW_END  = 2'd1;
   localparam logic [1:0] ST_NO_ROW   = 2'd2;

   // numerators and divisors of the grid steps fit in 18 signed bits
   localparam int NUM_W = 18;
   localparam int DIV_W = 18;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROW_TEST,
      S_DIV_SPX,
      S_DIV_SPY,
      S_DIV_EPX,
      S_DIV_EPY,
      S_ROW_ADV,
      S_PT_TEST,
      S_DIV_PX,
      S_PT_ADV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic signed [NUM_W-1:0] num;
      logic signed [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic signed [NUM_W-1:0] quot;
   } div_rsp_type;

   function automatic logic [10:0] sat11(input logic signed [17:0] v);
      logic [10:0] r;
      if (v > 18'sd1023) r = 11'h3FF;
      else if (v < -18'sd1024) r = 11'h400;
      else r = v[10:0];
      return r;
   endfunction

endpackage

/* src/ptagl_div.sv */
module ptagl_div (
   input  logic clock,
   input  logic reset,
   input  ptagl_pkg::div_req_type req,
   output ptagl_pkg::div_rsp_type rsp
);
   import ptagl_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [NUM_W:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dmag_ff, dmag_in;
   logic neg_ff, neg_in;
   logic [NUM_W:0] trial;
   logic [NUM_W-1:0] nmag;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   // restoring division on magnitudes, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      nmag    = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
      trial   = {rem_ff[NUM_W-1:0], q_ff[NUM_W-1]} - {1'b0, dmag_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         q_in    = nmag;
         rem_in  = '0;
         dmag_in = req.den[DIV_W-1] ? DIV_W'(-req.den) : DIV_W'(req.den);
         neg_in  = req.num[NUM_W-1] ^ req.den[DIV_W-1];
      end else if (busy_ff) begin
         if (!trial[NUM_W]) begin
            rem_in = trial;
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[NUM_W-1:0], q_ff[NUM_W-1]};
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = neg_ff ? -$signed(q_ff) : $signed(q_ff);

endmodule

/* src/pixel_to_arm_grid_locator.sv */
// channel  | ports                                   | direction
// request  | start, busy, req_coin_pixel_x/_y        | in (busy out)
// result   | rsp_valid, rsp_status, rsp_arm_x/_y     | out
// config   | csr_write, csr_index, csr_data          | in
//
// each row step does four divisions on the shared serial divider, each point
// step does one. busy is high from the accepting edge until the result strobe.
// reset clears the corners and control state. results cannot stall.
module pixel_to_arm_grid_locator (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [11:0] req_coin_pixel_x,
   input  logic [11:0] req_coin_pixel_y,
   output logic rsp_valid,
   output logic [1:0] rsp_status,
   output logic signed [10:0] rsp_arm_x,
   output logic signed [10:0] rsp_arm_y,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [ptagl_pkg::CORNER_W-1:0] csr_data
);
   import ptagl_pkg::*;

   typedef logic signed [NUM_W-1:0] v_type;

   logic [CORNER_W-1:0] corner_ff [NUM_CORNERS];
   state_type state_ff, state_in;
   logic [11:0] cx_ff, cx_in, cy_ff, cy_in;
   v_type spx_ff, spx_in, spy_ff, spy_in, say_ff, say_in;
   v_type epx_ff, epx_in, epy_ff, epy_in, eay_ff, eay_in;
   v_type px_ff, px_in, ax_ff, ax_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic valid_ff, valid_in;
   logic [1:0] stat_ff, stat_in;
   logic [10:0] ox_ff, ox_in, oy_ff, oy_in;
   div_req_type dreq;
   div_rsp_type drsp;

   v_type bl_px, bl_py, bl_ax, bl_ay, br_px, br_py, br_ax, br_ay;
   v_type tl_px, tl_py, tl_ay, tr_px, tr_py, tr_ay;

   always_comb begin
      bl_px = v_type'(corner_ff[REG_BL][15:0]);
      bl_py = v_type'(corner_ff[REG_BL][31:16]);
      bl_ax = v_type'($signed(corner_ff[REG_BL][47:32]));
      bl_ay = v_type'($signed(corner_ff[REG_BL][63:48]));
      br_px = v_type'(corner_ff[REG_BR][15:0]);
      br_py = v_type'(corner_ff[REG_BR][31:16]);
      br_ax = v_type'($signed(corner_ff[REG_BR][47:32]));
      br_ay = v_type'($signed(corner_ff[REG_BR][63:48]));
      tl_px = v_type'(corner_ff[REG_TL][15:0]);
      tl_py = v_type'(corner_ff[REG_TL][31:16]);
      tl_ay = v_type'($signed(corner_ff[REG_TL][63:48]));
      tr_px = v_type'(corner_ff[REG_TR][15:0]);
      tr_py = v_type'(corner_ff[REG_TR][31:16]);
      tr_ay = v_type'($signed(corner_ff[REG_TR][63:48]));
   end

   ptagl_div u_div (
      .clock(clock),
      .reset(reset),
      .req(dreq),
      .rsp(drsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CORNERS; i++) corner_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (csr_write) corner_ff[csr_index] <= csr_data;
      end
      cx_ff <= cx_in;   cy_ff <= cy_in;
      spx_ff <= spx_in; spy_ff <= spy_in; say_ff <= say_in;
      epx_ff <= epx_in; epy_ff <= epy_in; eay_ff <= eay_in;
      px_ff <= px_in;   ax_ff <= ax_in;   cnt_ff <= cnt_in;
      stat_ff <= stat_in; ox_ff <= ox_in; oy_ff <= oy_in;
   end

   always_comb begin
      state_in = state_ff;
      cx_in = cx_ff;   cy_in = cy_ff;
      spx_in = spx_ff; spy_in = spy_ff; say_in = say_ff;
      epx_in = epx_ff; epy_in = epy_ff; eay_in = eay_ff;
      px_in = px_ff;   ax_in = ax_ff;   cnt_in = cnt_ff;
      stat_in = stat_ff; ox_in = ox_ff; oy_in = oy_ff;
      valid_in = 1'b0;
      dreq = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cx_in = req_coin_pixel_x;
               cy_in = req_coin_pixel_y;
               spx_in = bl_px; spy_in = bl_py; say_in = bl_ay;
               epx_in = br_px; epy_in = br_py; eay_in = br_ay;
               cnt_in = STEP_W'(1);
               state_in = S_ROW_TEST;
            end
         end
         S_ROW_TEST: begin
            stat_in = ST_NO_ROW; ox_in = '0; oy_in = '0;
            if (v_type'(cy_ff) <= spy_ff) begin
               stat_in = ST_ROW_END;
               if (say_ff != eay_ff) begin
                  state_in = S_DONE;
               end else begin
                  px_in = spx_ff; ax_in = bl_ax; cnt_in = STEP_W'(1);
                  state_in = S_PT_TEST;
               end
            end else if (cnt_ff >= STEP_W'(MAX_STEPS) ||
                         !(say_ff < tl_ay && eay_ff < tr_ay)) begin
               state_in = S_DONE;
            end else begin
               dreq.start = 1'b1; dreq.num = tl_px - spx_ff; dreq.den = tl_ay - say_ff;
               state_in = S_DIV_SPX;
            end
         end
         S_DIV_SPX: if (drsp.done) begin
            spx_in = spx_ff + drsp.quot;
            dreq.start = 1'b1; dreq.num = tl_py - spy_ff; dreq.den = tl_ay - say_ff;
            state_in = S_DIV_SPY;
         end
         S_DIV_SPY: if (drsp.done) begin
            spy_in = spy_ff + drsp.quot;
            dreq.start = 1'b1; dreq.num = tr_px - epx_ff; dreq.den = tr_ay - eay_ff;
            state_in = S_DIV_EPX;
         end
         S_DIV_EPX: if (drsp.done) begin
            epx_in = epx_ff + drsp.quot;
            dreq.start = 1'b1; dreq.num = tr_py - epy_ff; dreq.den = tr_ay - eay_ff;
            state_in = S_DIV_EPY;
         end
         S_DIV_EPY: if (drsp.done) begin
            epy_in = epy_ff + drsp.quot;
            state_in = S_ROW_ADV;
         end
         S_ROW_ADV: begin
            say_in = say_ff + v_type'(1);
            eay_in = eay_ff + v_type'(1);
            cnt_in = cnt_ff + 1'b1;
            state_in = S_ROW_TEST;
         end
         S_PT_TEST: begin
            if (v_type'(cx_ff) <= px_ff) begin
               stat_in = ST_FOUND;
               ox_in = sat11(ax_ff);
               oy_in = sat11(say_ff);
               state_in = S_DONE;
            end else if (cnt_ff >= STEP_W'(MAX_STEPS) || !(ax_ff < br_ax)) begin
               state_in = S_DONE;
            end else begin
               dreq.start = 1'b1; dreq.num = br_px - px_ff; dreq.den = br_ax - ax_ff;
               state_in = S_DIV_PX;
            end
         end
         S_DIV_PX: if (drsp.done) begin
            px_in = px_ff + drsp.quot;
            state_in = S_PT_ADV;
         end
         S_PT_ADV: begin
            ax_in = ax_ff + v_type'(1);
            cnt_in = cnt_ff + 1'b1;
            state_in = S_PT_TEST;
         end
         S_DONE: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_status = stat_ff;
   assign rsp_arm_x = ox_ff;
   assign rsp_arm_y = oy_ff;

endmodule

/* src/ptagl_checker.sv */
module ptagl_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic [1:0] rsp_status,
   input logic signed [10:0] rsp_arm_x,
   input logic signed [10:0] rsp_arm_y
);
   import ptagl_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted transaction not busy");
   a_rsp_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without transaction");
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_FOUND || rsp_status == ST_ROW_END ||
                     rsp_status == ST_NO_ROW)) else $error("bad status");
   a_zero_unless_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_FOUND) |-> (rsp_arm_x == 0 && rsp_arm_y == 0))
      else $error("coordinates not zero");

endmodule

bind pixel_to_arm_grid_locator ptagl_checker u_ptagl_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_status(rsp_status),
   .rsp_arm_x(rsp_arm_x),
   .rsp_arm_y(rsp_arm_y)
);

/* tb/tb_pixel_to_arm_grid_locator.sv */
`timescale 1ns / 1ps

module tb_pixel_to_arm_grid_locator;
   import ptagl_pkg::*;

   localparam longint CYCLE_LIMIT = 40_000_000;

   typedef struct {
      logic [11:0] cx;
      logic [11:0] cy;
   } coin_t;

   typedef struct {
      logic [1:0] status;
      logic signed [10:0] ax;
      logic signed [10:0] ay;
   } location_t;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [11:0] req_coin_pixel_x;
   logic [11:0] req_coin_pixel_y;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic signed [10:0] rsp_arm_x;
   logic signed [10:0] rsp_arm_y;
   logic csr_write;
   logic [1:0] csr_index;
   logic [CORNER_W-1:0] csr_data;

   logic [CORNER_W-1:0] corners [NUM_CORNERS];
   coin_t coin_q [$];
   location_t location_q [$];
   int mismatches;
   int gap;
   longint cycles;

   pixel_to_arm_grid_locator uut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int pix_x(logic [CORNER_W-1:0] c);
      return int'(c[15:0]);
   endfunction

   function automatic int pix_y(logic [CORNER_W-1:0] c);
      return int'(c[31:16]);
   endfunction

   function automatic int arm_x(logic [CORNER_W-1:0] c);
      return int'($signed(c[47:32]));
   endfunction

   function automatic int arm_y(logic [CORNER_W-1:0] c);
      return int'($signed(c[63:48]));
   endfunction

   function automatic logic [10:0] clamp11(int v);
      if (v > 1023) v = 1023;
      if (v < -1024) v = -1024;
      return v[10:0];
   endfunction

   // walks the grid rows upward, then the points of the chosen row
   function automatic location_t locate_coin(int cx, int cy);
      location_t r;
      int spx, spy, say, epx, epy, eay;
      int rows, k, px, ax;
      bit row_hit, pt_hit;
      spx = pix_x(corners[REG_BL]);
      spy = pix_y(corners[REG_BL]);
      say = arm_y(corners[REG_BL]);
      epx = pix_x(corners[REG_BR]);
      epy = pix_y(corners[REG_BR]);
      eay = arm_y(corners[REG_BR]);
      rows = 0;
      row_hit = 0;
      pt_hit = 0;
      r.status = ST_NO_ROW;
      r.ax = '0;
      r.ay = '0;
      forever begin
         rows++;
         if (cy <= spy) begin
            row_hit = 1;
            break;
         end
         if (rows >= MAX_STEPS) break;
         if (!(say < arm_y(corners[REG_TL]) && eay < arm_y(corners[REG_TR]))) break;
         spx += (pix_x(corners[REG_TL]) - spx) / (arm_y(corners[REG_TL]) - say);
         spy += (pix_y(corners[REG_TL]) - spy) / (arm_y(corners[REG_TL]) - say);
         say++;
         epx += (pix_x(corners[REG_TR]) - epx) / (arm_y(corners[REG_TR]) - eay);
         epy += (pix_y(corners[REG_TR]) - epy) / (arm_y(corners[REG_TR]) - eay);
         eay++;
      end
      if (!row_hit) return r;
      r.status = ST_ROW_END;
      if (say != eay) return r;
      px = spx;
      ax = arm_x(corners[REG_BL]);
      k = 0;
      forever begin
         k++;
         if (cx <= px) begin
            pt_hit = 1;
            break;
         end
         if (k >= MAX_STEPS) break;
         if (!(ax < arm_x(corners[REG_BR]))) break;
         px += (pix_x(corners[REG_BR]) - px) / (arm_x(corners[REG_BR]) - ax);
         ax++;
      end
      if (pt_hit) begin
         r.status = ST_FOUND;
         r.ax = clamp11(ax);
         r.ay = clamp11(say);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("t=%0t %s: got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // driver: one transaction at a time, random gap after each acceptance
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap <= 0;
      end else if (start && !busy) begin
         location_q.push_back(locate_coin(req_coin_pixel_x, req_coin_pixel_y));
         start <= 1'b0;
         gap <= $urandom_range(0, 6);
      end else if (!start) begin
         if (gap > 0) begin
            gap <= gap - 1;
         end else if (coin_q.size() > 0) begin
            req_coin_pixel_x <= coin_q[0].cx;
            req_coin_pixel_y <= coin_q[0].cy;
            coin_q.pop_front();
            start <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      location_t want;
      if (!reset && rsp_valid) begin
         if (location_q.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_status, -1);
         end else begin
            want = location_q.pop_front();
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_arm_x !== want.ax) report_mismatch("arm_x", rsp_arm_x, want.ax);
            if (rsp_arm_y !== want.ay) report_mismatch("arm_y", rsp_arm_y, want.ay);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [CORNER_W-1:0] pack_corner(int px, int py, int ax, int ay);
      logic [15:0] fx, fy, fax, fay;
      fx = px[15:0];
      fy = py[15:0];
      fax = ax[15:0];
      fay = ay[15:0];
      return {fay, fax, fy, fx};
   endfunction

   task automatic wait_idle();
      while (coin_q.size() > 0 || start || busy || location_q.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_corner(logic [1:0] idx, logic [CORNER_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      corners[idx] = val;
   endtask

   task automatic load_grid(logic [CORNER_W-1:0] bl, logic [CORNER_W-1:0] br,
                            logic [CORNER_W-1:0] tl, logic [CORNER_W-1:0] tr);
      wait_idle();
      write_corner(REG_BL, bl);
      write_corner(REG_BR, br);
      write_corner(REG_TL, tl);
      write_corner(REG_TR, tr);
   endtask

   task automatic queue_coin(int cx, int cy);
      coin_t c;
      c.cx = cx[11:0];
      c.cy = cy[11:0];
      coin_q.push_back(c);
   endtask

   // mostly coins within 0..span on both axes, the rest anywhere
   task automatic queue_random_coins(int n, int span);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) queue_coin($urandom, $urandom);
         else queue_coin($urandom_range(0, span), $urandom_range(0, span));
      end
   endtask

   task automatic random_grid(int max_rows, int max_pts);
      int bpx, bpy, bax, bay, rspan, pspan, eay, ws;
      bpx = $urandom_range(0, 800);
      bpy = $urandom_range(0, 800);
      bax = $urandom_range(0, 200) - 100;
      bay = $urandom_range(0, 200) - 100;
      // occasionally a degenerate span: top not above bottom, or right not right of left
      rspan = ($urandom_range(0, 7) == 0) ? -int'($urandom_range(0, 3)) : $urandom_range(1, max_rows);
      pspan = ($urandom_range(0, 7) == 0) ? -int'($urandom_range(0, 3)) : $urandom_range(1, max_pts);
      eay = ($urandom_range(0, 5) == 0) ? bay + $urandom_range(1, 2) : bay;
      ws = $urandom_range(100, 3000);
      load_grid(pack_corner(bpx, bpy, bax, bay),
                pack_corner(bpx + ws, bpy + $urandom_range(0, 300), bax + pspan, eay),
                pack_corner(bpx + $urandom_range(0, 300), bpy + $urandom_range(0, 3000),
                            $urandom_range(0, 65535), bay + rspan),
                pack_corner($urandom_range(0, 4095), bpy + $urandom_range(0, 3000),
                            $urandom_range(0, 65535), eay + rspan));
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_coin_pixel_x <= '0;
      req_coin_pixel_y <= '0;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      cycles <= 0;
      mismatches = 0;
      for (int i = 0; i < NUM_CORNERS; i++) corners[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // all corners zero after reset
      queue_coin(0, 0);
      queue_coin(4095, 0);
      queue_coin(0, 1);

      // regular grid
      load_grid(pack_corner(100, 100, -5, 10), pack_corner(900, 120, 5, 10),
                pack_corner(120, 2000, 0, 20), pack_corner(880, 2100, 0, 20));
      queue_coin(0, 0);
      queue_coin(100, 100);
      queue_coin(101, 101);
      queue_coin(500, 1000);
      queue_coin(899, 1500);
      queue_coin(4095, 500);
      queue_coin(300, 2000);
      queue_coin(300, 4095);

      // bottom arm y differ
      load_grid(pack_corner(100, 100, -5, 10), pack_corner(900, 120, 5, 11),
                pack_corner(120, 2000, 0, 20), pack_corner(880, 2100, 0, 20));
      queue_coin(50, 50);
      queue_coin(500, 1000);

      // saturating arm coordinates, right edge left of left edge
      load_grid(pack_corner(10, 10, 2000, -2000), pack_corner(4000, 10, 2010, -2000),
                pack_corner(10, 3000, 0, -1990), pack_corner(4000, 3000, 0, -1990));
      queue_coin(4000, 5);
      queue_coin(0, 2000);
      load_grid(pack_corner(10, 10, -2000, 3000), pack_corner(4000, 10, -2010, 3000),
                pack_corner(10, 3000, 0, 3005), pack_corner(4000, 3000, 0, 3005));
      queue_coin(0, 0);
      queue_coin(5, 0);

      // long spans reaching the row and point caps
      load_grid(pack_corner(0, 0, -400, -300), pack_corner(4095, 0, 400, -300),
                pack_corner(0, 4095, 0, 300), pack_corner(4095, 4095, 0, 300));
      queue_coin(4095, 4095);
      queue_coin(4095, 100);
      queue_coin(10, 4095);

      // all ones and full random corners
      load_grid('1, '1, '1, '1);
      queue_random_coins(3, 4095);
      for (int p = 0; p < 2; p++) begin
         load_grid({$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
         queue_random_coins(4, 4095);
      end

      for (int p = 0; p < 8; p++) begin
         random_grid(14, 14);
         queue_random_coins(11, 4095);
      end
      random_grid(300, 300);
      queue_random_coins(5, 4095);

      wait_idle();
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/ptagl_pkg.sv
src/ptagl_div.sv
src/pixel_to_arm_grid_locator.sv
src/ptagl_checker.sv
tb/tb_pixel_to_arm_grid_locator.sv
